// ----- rtl/blt_pkg.sv -----
// Shared types, sizes and the blue fade table for the bouncing line trail.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package blt_pkg;

   // trail geometry
   localparam int TRAIL_LENGTH = 25;
   localparam int COORD_BITS   = 10;
   localparam int AREA_W       = 10;
   localparam int VEL_W        = 3;
   localparam int BLUE_W       = 8;

   // older segments live in a ring; the head is kept in flops
   localparam int HIST_DEPTH = TRAIL_LENGTH - 1;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
   localparam int IDX_W      = $clog2(TRAIL_LENGTH + 1);

   // signed width for stepped coordinates and limits
   localparam int STEP_W = ((COORD_BITS > AREA_W) ? COORD_BITS : AREA_W) + 2;

   // CSR map
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;
   localparam logic REG_AREA_RIGHT  = 1'b0;
   localparam logic REG_AREA_BOTTOM = 1'b1;

   typedef logic [COORD_BITS-1:0]       coord_type;
   typedef coord_type [3:0]             segment_type;   // x0, y0, x1, y1
   typedef logic signed [VEL_W-1:0]     vel_type;
   typedef vel_type [3:0]               vel_set_type;
   typedef logic [AREA_W-1:0]           area_type;
   typedef logic [BLUE_W-1:0]           blue_table_type [TRAIL_LENGTH];

   // result of one step of the shared coordinate unit
   typedef struct packed {
      coord_type coord;
      vel_type   vel;
   } step_result_type;

   // blue fades from 255 toward black; the oldest slot is black
   function automatic blue_table_type blue_table_init();
      blue_table_type t;
      for (int i = 0; i < TRAIL_LENGTH; i++) begin
         if (i == TRAIL_LENGTH - 1) begin
            t[i] = '0;
         end else begin
            t[i] = BLUE_W'(255 - (255 * i) / TRAIL_LENGTH);
         end
      end
      return t;
   endfunction

   localparam blue_table_type BLUE_TABLE = blue_table_init();

endpackage

// ----- rtl/blt_step_unit.sv -----
// Shared coordinate step unit: adds a velocity, bounces off the area edges.
// Depends on blt_pkg.
`timescale 1ns / 1ps

module blt_step_unit
   import blt_pkg::*;
(
   input  coord_type       pos,
   input  vel_type         vel,
   input  area_type        area,
   output step_result_type result
);

   logic signed [STEP_W-1:0] stepped;
   logic signed [STEP_W-1:0] limit;
   logic                     bounce;

   // step and limit in signed arithmetic so tiny areas still behave
   assign stepped = $signed({{(STEP_W-COORD_BITS){1'b0}}, pos}) + STEP_W'(vel);
   assign limit   = $signed({{(STEP_W-AREA_W){1'b0}}, area}) - STEP_W'(1);
   assign bounce  = (stepped < STEP_W'(1)) || (stepped > limit);

   // a bounce flips the velocity and lands back on the old position
   always_comb begin
      if (bounce) begin
         result.coord = pos;
         result.vel   = -vel;
      end else begin
         result.coord = stepped[COORD_BITS-1:0];
         result.vel   = vel;
      end
   end

endmodule

// ----- rtl/bouncing_line_trail.sv -----
// Bouncing line trail top level: CSRs, sequencer, history ring, result register.
// Depends on blt_pkg and blt_step_unit.
//
//   channel | ports                         | role
//   --------+-------------------------------+--------------------------------
//   req     | req_valid/ready, req_hold     | one tick item in
//   rsp     | rsp_valid/ready, rsp_*        | one segment item out, newest first
//   csr     | csr_psel..csr_prdata          | area_right @0x0, area_bottom @0x4
//
// A tick with hold set is accepted and yields nothing.
// Other ticks: the head is pushed into the history ring, then the four
// coordinates go one at a time through the shared step unit, then one segment
// per cycle while rsp does not stall; the single step unit and ring port set this pace.
// req_ready is low from the tick until its last segment is loaded in rsp.
// rsp stalls hold the sequencer; synchronous reset restores the start trail.
`timescale 1ns / 1ps

module bouncing_line_trail
   import blt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_hold,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output coord_type         rsp_start_x,
   output coord_type         rsp_start_y,
   output coord_type         rsp_end_x,
   output coord_type         rsp_end_y,
   output logic [BLUE_W-1:0] rsp_blue_level,
   output logic              rsp_final_segment,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHIFT = 2'd1;
   localparam logic [1:0] S_MOVE  = 2'd2;
   localparam logic [1:0] S_EMIT  = 2'd3;

   logic [1:0]         state_ff, state_in;
   area_type           right_ff, bottom_ff;
   segment_type        head_ff;
   vel_set_type        vel_ff;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [HIST_AW-1:0] wp_ff, wp_in;
   logic [1:0]         k_ff, k_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   segment_type        rdata_ff;
   segment_type        hist_mem [HIST_DEPTH];

   logic               rsp_valid_ff, rsp_valid_in;
   segment_type        rsp_seg_ff;
   logic [BLUE_W-1:0]  rsp_blue_ff;
   logic               rsp_final_ff;

   logic               csr_wr;
   logic               accept;
   logic               load;
   logic               last;
   logic [HIST_AW-1:0] rd_addr;
   logic [IDX_W:0]     rd_sum;
   area_type           step_area;
   step_result_type    step;
   segment_type        out_seg;

   // CSR port: always ready, word select on address bit 2
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = CSR_DW'(csr_paddr[2] ? bottom_ff : right_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff  <= AREA_W'(200);
         bottom_ff <= AREA_W'(200);
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_AREA_RIGHT:  right_ff  <= csr_pwdata[AREA_W-1:0];
            REG_AREA_BOTTOM: bottom_ff <= csr_pwdata[AREA_W-1:0];
            default:         right_ff  <= right_ff;
         endcase
      end
   end

   // shared step unit; odd coordinates are vertical
   assign step_area = k_ff[0] ? bottom_ff : right_ff;

   blt_step_unit u_step (
      .pos    (head_ff[k_ff]),
      .vel    (vel_ff[k_ff]),
      .area   (step_area),
      .result (step)
   );

   // emit control
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign last      = (idx_ff == count_ff - IDX_W'(1));
   assign load      = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_ready) &&
                      ((idx_ff == '0) || (rd_idx_ff == idx_ff));

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      wp_in     = wp_ff;
      k_in      = k_ff;
      idx_in    = idx_ff;
      rd_idx_in = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && !req_hold) begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (count_ff < IDX_W'(TRAIL_LENGTH)) begin
               count_in = count_ff + IDX_W'(1);
            end
            wp_in    = (wp_ff == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wp_ff + HIST_AW'(1);
            k_in     = '0;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               idx_in    = '0;
               rd_idx_in = '0;
               state_in  = S_EMIT;
            end
         end
         S_EMIT: begin
            if (load) begin
               idx_in    = idx_ff + IDX_W'(1);
               rd_idx_in = idx_ff + IDX_W'(1);
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= IDX_W'(1);
         wp_ff     <= '0;
         k_ff      <= '0;
         idx_ff    <= '0;
         rd_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         wp_ff     <= wp_in;
         k_ff      <= k_in;
         idx_ff    <= idx_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   // head segment and velocities, one coordinate per move cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff[0] <= COORD_BITS'(50);
         head_ff[1] <= COORD_BITS'(50);
         head_ff[2] <= COORD_BITS'(100);
         head_ff[3] <= COORD_BITS'(100);
         vel_ff[0]  <= VEL_W'(2);
         vel_ff[1]  <= -VEL_W'(3);
         vel_ff[2]  <= -VEL_W'(1);
         vel_ff[3]  <= VEL_W'(3);
      end else if (state_ff == S_MOVE) begin
         head_ff[k_ff] <= step.coord;
         vel_ff[k_ff]  <= step.vel;
      end
   end

   // history ring: slot n (n >= 1) sits n entries behind the write pointer
   always_comb begin
      if ({1'b0, wp_ff} >= {1'b0, rd_idx_in}) begin
         rd_sum = (IDX_W+1)'(wp_ff) - (IDX_W+1)'(rd_idx_in);
      end else begin
         rd_sum = (IDX_W+1)'(wp_ff) + (IDX_W+1)'(HIST_DEPTH) - (IDX_W+1)'(rd_idx_in);
      end
      rd_addr = rd_sum[HIST_AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SHIFT) begin
         hist_mem[wp_ff] <= head_ff;
      end
      rdata_ff <= hist_mem[rd_addr];
   end

   // result register
   assign out_seg      = (idx_ff == '0) ? head_ff : rdata_ff;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_seg_ff   <= out_seg;
         rsp_blue_ff  <= BLUE_TABLE[idx_ff];
         rsp_final_ff <= last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_start_x       = rsp_seg_ff[0];
   assign rsp_start_y       = rsp_seg_ff[1];
   assign rsp_end_x         = rsp_seg_ff[2];
   assign rsp_end_y         = rsp_seg_ff[3];
   assign rsp_blue_level    = rsp_blue_ff;
   assign rsp_final_segment = rsp_final_ff;

endmodule

// ----- rtl/blt_checker.sv -----
// Port-level checks for bouncing_line_trail, attached by the bind below.
// Depends on blt_pkg and the bouncing_line_trail port list.
`timescale 1ns / 1ps

module blt_checker
   import blt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_hold,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input coord_type         rsp_start_x,
   input logic              rsp_final_segment,
   input logic              csr_pready
);

   // a held tick leaves the block idle
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_hold |=> req_ready)
      else $error("held tick made the block busy");

   // a live tick makes the block busy
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_hold |=> !req_ready)
      else $error("tick did not start work");

   // no new tick while a trail is only partly delivered
   a_busy_mid_trail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_segment |-> !req_ready)
      else $error("ready during an unfinished trail");

   // a stalled segment item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_start_x) &&
      $stable(rsp_final_segment))
      else $error("stalled segment item changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr_pready dropped");

endmodule

bind bouncing_line_trail blt_checker u_blt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_hold          (req_hold),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_start_x       (rsp_start_x),
   .rsp_final_segment (rsp_final_segment),
   .csr_pready        (csr_pready)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for bouncing_line_trail: ticks in, trail segments out.
// Depends on blt_pkg and the bouncing_line_trail RTL; predicts every segment in-line.
`timescale 1ns / 1ps

module tb_top;
   import blt_pkg::*;

   localparam logic [CSR_AW-1:0] ADDR_AREA_RIGHT  = CSR_AW'(4 * int'(REG_AREA_RIGHT));
   localparam logic [CSR_AW-1:0] ADDR_AREA_BOTTOM = CSR_AW'(4 * int'(REG_AREA_BOTTOM));
   localparam int DRAIN_GUARD = 20000;
   localparam int SETTLE_CYCLES = 40;

   // one segment item as it should leave the block
   typedef struct {
      coord_type         start_x;
      coord_type         start_y;
      coord_type         end_x;
      coord_type         end_y;
      logic [BLUE_W-1:0] blue;
      logic              last_seg;
   } seg_item_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_hold = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   coord_type         rsp_start_x;
   coord_type         rsp_start_y;
   coord_type         rsp_end_x;
   coord_type         rsp_end_y;
   logic [BLUE_W-1:0] rsp_blue_level;
   logic              rsp_final_segment;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // trail predictor state
   segment_type trail_pos [TRAIL_LENGTH];
   int          head_step [4];
   int          seg_count;
   area_type    area_x;
   area_type    area_y;

   seg_item_t   seg_expect_q [$];
   seg_item_t   seg_got;
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   bouncing_line_trail u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_hold          (req_hold),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_start_x       (rsp_start_x),
      .rsp_start_y       (rsp_start_y),
      .rsp_end_x         (rsp_end_x),
      .rsp_end_y         (rsp_end_y),
      .rsp_blue_level    (rsp_blue_level),
      .rsp_final_segment (rsp_final_segment),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic void note_error(string what);
      mismatch_count++;
      $display("%0t: %s", $time, what);
   endfunction

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         note_error($sformatf("%s mismatch: expected %0d, actual %0d", name, want, got));
      end
   endfunction

   function automatic void reset_trail();
      for (int i = 0; i < TRAIL_LENGTH; i++) begin
         trail_pos[i] = '0;
      end
      trail_pos[0][0] = COORD_BITS'(50);
      trail_pos[0][1] = COORD_BITS'(50);
      trail_pos[0][2] = COORD_BITS'(100);
      trail_pos[0][3] = COORD_BITS'(100);
      head_step[0] = 2;
      head_step[1] = -3;
      head_step[2] = -1;
      head_step[3] = 3;
      seg_count = 1;
      area_x = AREA_W'(200);
      area_y = AREA_W'(200);
   endfunction

   // step one head coordinate, reflecting off the edges of the area
   function automatic void bounce_coord(int k, area_type area);
      int lim;
      int q;
      lim = int'(area) - 1;
      q = int'(trail_pos[0][k]) + head_step[k];
      if (q < 1 || q > lim) begin
         head_step[k] = -head_step[k];
         q = q + head_step[k];
      end
      trail_pos[0][k] = coord_type'(q);
   endfunction

   // one tick: age the trail, move the head, queue every segment newest first
   function automatic void advance_trail();
      seg_item_t s;
      if (seg_count < TRAIL_LENGTH) begin
         seg_count++;
      end
      for (int i = seg_count - 1; i >= 1; i--) begin
         trail_pos[i] = trail_pos[i-1];
      end
      bounce_coord(0, area_x);
      bounce_coord(1, area_y);
      bounce_coord(2, area_x);
      bounce_coord(3, area_y);
      for (int i = 0; i < seg_count; i++) begin
         s.start_x  = trail_pos[i][0];
         s.start_y  = trail_pos[i][1];
         s.end_x    = trail_pos[i][2];
         s.end_y    = trail_pos[i][3];
         s.blue     = (i == TRAIL_LENGTH - 1) ? '0 : BLUE_W'(255 - (255 * i) / TRAIL_LENGTH);
         s.last_seg = (i == seg_count - 1);
         seg_expect_q.push_back(s);
      end
   endfunction

   // segment checker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (seg_expect_q.size() == 0) begin
            note_error($sformatf("unexpected segment item: expected none, actual %0d,%0d,%0d,%0d",
                                 rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y));
         end else begin
            seg_got = seg_expect_q.pop_front();
            check_field("start_x", seg_got.start_x, rsp_start_x);
            check_field("start_y", seg_got.start_y, rsp_start_y);
            check_field("end_x", seg_got.end_x, rsp_end_x);
            check_field("end_y", seg_got.end_y, rsp_end_y);
            check_field("blue_level", seg_got.blue, rsp_blue_level);
            check_field("final_segment", seg_got.last_seg, rsp_final_segment);
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // send one tick item; entered and left at a falling edge
   task automatic send_tick(input logic hold);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_hold  <= hold;
      do @(posedge clock); while (!req_ready);
      if (!hold) begin
         advance_trail();
      end
      @(negedge clock);
   endtask

   // hold off the sender until every segment has come, then let the block settle
   task automatic wait_drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (seg_expect_q.size() != 0 && guard < DRAIN_GUARD) begin
         @(negedge clock);
         guard++;
      end
      if (seg_expect_q.size() != 0) begin
         note_error($sformatf("segments never arrived: expected %0d more, actual 0",
                              seg_expect_q.size()));
         seg_expect_q.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [CSR_AW-1:0] addr,
                             input logic [CSR_DW-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (wr) begin
         if (addr == ADDR_AREA_RIGHT) begin
            area_x = data[AREA_W-1:0];
         end else if (addr == ADDR_AREA_BOTTOM) begin
            area_y = data[AREA_W-1:0];
         end
      end else begin
         check_field("prdata", (addr == ADDR_AREA_RIGHT) ? area_x : area_y, csr_prdata);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // write both limits and read them back; only called with the block idle
   task automatic set_area(input logic [CSR_DW-1:0] right, input logic [CSR_DW-1:0] bottom);
      csr_access(1'b1, ADDR_AREA_RIGHT, right);
      csr_access(1'b1, ADDR_AREA_BOTTOM, bottom);
      csr_access(1'b0, ADDR_AREA_RIGHT, '0);
      csr_access(1'b0, ADDR_AREA_BOTTOM, '0);
   endtask

   // mostly small areas so the head bounces often; junk in the upper data bits
   function automatic logic [CSR_DW-1:0] pick_area();
      logic [CSR_DW-1:0] v;
      int                edges [6] = '{0, 1, 2, 3, 1022, 1023};
      int                sel;
      v = $urandom;
      sel = $urandom_range(9);
      if (sel < 4) begin
         v[AREA_W-1:0] = AREA_W'($urandom_range(40, 4));
      end else if (sel < 6) begin
         v[AREA_W-1:0] = AREA_W'(edges[$urandom_range(5)]);
      end else begin
         v[AREA_W-1:0] = AREA_W'($urandom_range(1023, 4));
      end
      return v;
   endfunction

   // reset limits, hold ticks, trail growing to full length and saturating
   task automatic test_fill_trail();
      csr_access(1'b0, ADDR_AREA_RIGHT, '0);
      csr_access(1'b0, ADDR_AREA_BOTTOM, '0);
      send_tick(1'b1);
      repeat (TRAIL_LENGTH - 1) send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_drain();
   endtask

   // low-end limit below the head, limits below range, and the top limit
   task automatic test_area_extremes();
      set_area(32'd4, 32'd4);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_drain();
      set_area(32'd0, 32'd1);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_drain();
      set_area(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_tick(1'b0);
      send_tick(1'b0);
      wait_drain();
   endtask

   // random ticks under one idling mix, re-programming the area between blocks
   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (2) begin
         wait_drain();
         set_area(pick_area(), pick_area());
         repeat (40) begin
            send_tick($urandom_range(99) < 15);
            if ($urandom_range(59) == 0) begin
               wait_drain();
            end
         end
      end
      wait_drain();
   endtask

   initial begin
      reset_trail();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_fill_trail();
      test_area_extremes();
      test_random_traffic(0, 0);
      test_random_traffic(75, 0);
      test_random_traffic(0, 75);
      test_random_traffic(25, 25);

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_drain();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/blt_pkg.sv
rtl/blt_step_unit.sv
rtl/bouncing_line_trail.sv
rtl/blt_checker.sv
tb/sv/tb_top.sv
